[rtl/core/slu_pkg.sv]
// Package for the serial line unit register block.
// Item kinds, register offsets, status bit positions and write masks.
// No dependencies.
`timescale 1ns / 1ps

package slu_pkg;

    // Item kinds carried on s_tuser
    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_CHAR  = 3'd2;
    localparam logic [2:0] KIND_TICK  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;
    localparam logic [2:0] KIND_RESET = 3'd5;

    // Device register selects
    localparam logic [1:0] REG_RCSR = 2'd0;
    localparam logic [1:0] REG_RBUF = 2'd1;
    localparam logic [1:0] REG_XCSR = 2'd2;
    localparam logic [1:0] REG_XBUF = 2'd3;

    // Configuration register selects (paddr bit 2)
    localparam logic CFG_VECTOR    = 1'b0;
    localparam logic CFG_CHAR_TIME = 1'b1;

    localparam logic [8:0]  VECTOR_RESET    = 9'd48;
    localparam logic [15:0] CHAR_TIME_RESET = 16'd1000;
    localparam logic [9:0]  XMT_VECTOR_OFS  = 10'd4;

    // Receiver status bits
    localparam int RC_RDR_ENB = 0;
    localparam int RC_DS_ENB  = 5;
    localparam int RC_INT_ENB = 6;
    localparam int RC_DONE    = 7;
    localparam int RC_ACT     = 11;
    localparam int RC_DS_INT  = 15;
    localparam logic [15:0] RC_WMASK = 16'h0041;

    // Receiver buffer bits
    localparam int RB_OVR = 14;
    localparam int RB_ERR = 15;

    // Transmitter status bits
    localparam int XC_MAINT   = 2;
    localparam int XC_INT_ENB = 6;
    localparam int XC_RDY     = 7;
    localparam logic [15:0] XC_WMASK = 16'h0045;
    localparam logic [15:0] XC_RESET = 16'h0080;

    // Byte-enable merge of a 16-bit word
    function automatic logic [15:0] merge16(input logic [15:0] old_w,
                                            input logic [15:0] new_w,
                                            input logic [1:0]  be);
        logic [15:0] m;
        m = {{8{be[1]}}, {8{be[0]}}};
        return (old_w & ~m) | (new_w & m);
    endfunction

endpackage

[rtl/core/serial_line_unit_registers.sv]
// Serial line unit: four device registers, receive and transmit character
// timers, loopback and interrupt logic behind a stream port and an APB port.
// Depends on slu_pkg.
//
// Input register, then the result register fed by one pass of combinational
// update logic, in which all device state updates are made.
// Throughput: one item per cycle while the result register is free or drains.
// Reset: synchronous, active low on aresetn; clears the device state, the
// configuration registers (vector 48, 1000 ticks per character) and both
// channel valid flags. A reset item clears the device state only.
`timescale 1ns / 1ps

module serial_line_unit_registers
    import slu_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // reg_index[1:0], write_data[17:2],
                                   // byte_enable[19:18], incoming_char[27:20]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[15:0], char_accepted[16],
                                   // line_out_valid[17], line_out_char[25:18],
                                   // irq_line[26], ack_vector[36:27]
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    typedef struct packed {
        logic [15:0]            rcv_status;
        logic [15:0]            rcv_buffer;
        logic [15:0]            xmt_status;
        logic [7:0]             xmt_data;
        logic                   xmt_pending;
        logic                   xmt_busy;
        logic [TIMER_WIDTH-1:0] xmt_timer;
        logic [7:0]             xmt_shift_char;
        logic                   rcv_busy;
        logic [TIMER_WIDTH-1:0] rcv_timer;
        logic [7:0]             rcv_shift_char;
        logic                   irq_request;
    } dev_state_t;

    // Interrupt level from the enable and flag bits
    function automatic logic irq_level(input dev_state_t st);
        return (st.rcv_status[RC_DS_ENB]  & st.rcv_status[RC_DS_INT]) |
               (st.rcv_status[RC_INT_ENB] & st.rcv_status[RC_DONE])   |
               (st.xmt_status[XC_INT_ENB] & st.xmt_status[XC_RDY]);
    endfunction

    // Begin assembling a character if the receiver is idle
    function automatic dev_state_t start_rx(input dev_state_t st,
                                            input logic [7:0] ch,
                                            input logic [TIMER_WIDTH-1:0] load);
        dev_state_t r;
        r = st;
        if (!st.rcv_busy) begin
            r.rcv_status[RC_ACT] = 1'b1;
            r.rcv_busy           = 1'b1;
            r.rcv_timer          = load;
            r.rcv_shift_char     = ch;
        end
        return r;
    endfunction

    // Begin sending the buffered character, or queue it behind the current one
    function automatic dev_state_t start_tx(input dev_state_t st,
                                            input logic [TIMER_WIDTH-1:0] load);
        dev_state_t r;
        r = st;
        if (!st.xmt_status[XC_RDY]) begin
            r.xmt_pending = 1'b1;
        end else begin
            r.xmt_pending        = 1'b0;
            r.xmt_status[XC_RDY] = 1'b0;
            r.xmt_shift_char     = st.xmt_data;
            r.xmt_busy           = 1'b1;
            r.xmt_timer          = load;
            if (st.xmt_status[XC_MAINT]) begin
                r = start_rx(r, r.xmt_shift_char, load);
            end
            r.irq_request = irq_level(r);
        end
        return r;
    endfunction

    function automatic dev_state_t reset_state();
        dev_state_t r;
        r            = '0;
        r.xmt_status = XC_RESET;
        r.irq_request = irq_level(r);
        return r;
    endfunction

    // Configuration registers
    logic [8:0]  vector_base_reg;
    logic [15:0] char_time_reg;

    // Input register
    logic        in_valid_reg;
    logic [2:0]  in_kind_reg;
    logic [1:0]  in_reg_index_reg;
    logic [15:0] in_write_data_reg;
    logic [1:0]  in_byte_enable_reg;
    logic [7:0]  in_char_reg;

    // Device state and result register
    dev_state_t  st_reg, st_next;
    logic        out_valid_reg;
    logic [39:0] out_data_reg, out_data_next;

    logic                   proc_fire;
    logic                   cfg_write;
    logic [31:0]            char_time_wide;
    logic [TIMER_WIDTH-1:0] load_time;

    // Result fields of the item in the input register
    logic [15:0] rd;
    logic        acc;
    logic        lv;
    logic [7:0]  lc;
    logic [9:0]  vec;
    logic [15:0] merged;
    logic        rx_was_busy;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // Configuration read-back
    always_comb begin
        case (paddr[2])
            CFG_VECTOR:    prdata = {23'd0, vector_base_reg};
            CFG_CHAR_TIME: prdata = {16'd0, char_time_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Character time in timer width, zero counts as one
    assign char_time_wide = {16'd0, char_time_reg};
    always_comb begin
        load_time = char_time_wide[TIMER_WIDTH-1:0];
        if (load_time == '0) begin
            load_time = TIMER_ONE;
        end
    end

    // Process the held item when the result register is free or draining
    assign proc_fire = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Device state update for one item
    always_comb begin
        st_next     = st_reg;
        rd          = 16'd0;
        acc         = 1'b0;
        lv          = 1'b0;
        lc          = 8'd0;
        vec         = 10'd0;
        merged      = 16'd0;
        rx_was_busy = st_reg.rcv_busy;

        case (in_kind_reg)
            KIND_READ: begin
                case (in_reg_index_reg)
                    REG_RCSR: begin
                        rd = st_reg.rcv_status;
                        st_next.rcv_status[RC_DS_INT] = 1'b0;
                        st_next.irq_request = irq_level(st_next);
                    end
                    REG_RBUF: begin
                        rd = st_reg.rcv_buffer;
                        st_next.rcv_status[RC_DONE] = 1'b0;
                        st_next.irq_request = irq_level(st_next);
                    end
                    REG_XCSR: rd = st_reg.xmt_status;
                    default:  rd = {8'd0, st_reg.xmt_data};
                endcase
            end
            KIND_WRITE: begin
                case (in_reg_index_reg)
                    REG_RCSR: begin
                        merged = merge16(st_reg.rcv_status, in_write_data_reg,
                                         in_byte_enable_reg);
                        st_next.rcv_status = (st_reg.rcv_status & ~RC_WMASK) |
                                             (merged & RC_WMASK);
                        if (merged[RC_RDR_ENB]) begin
                            st_next.rcv_status[RC_DONE] = 1'b0;
                        end
                        st_next.irq_request = irq_level(st_next);
                    end
                    REG_RBUF: begin
                        st_next.rcv_status[RC_DONE] = 1'b0;
                        st_next.irq_request = irq_level(st_next);
                    end
                    REG_XCSR: begin
                        merged = merge16(st_reg.xmt_status, in_write_data_reg,
                                         in_byte_enable_reg);
                        st_next.xmt_status = (st_reg.xmt_status & ~XC_WMASK) |
                                             (merged & XC_WMASK);
                        // Entering loopback cancels any receive in progress
                        if (merged[XC_MAINT]) begin
                            st_next.rcv_busy           = 1'b0;
                            st_next.rcv_timer          = '0;
                            st_next.rcv_status[RC_ACT] = 1'b0;
                        end
                        st_next.irq_request = irq_level(st_next);
                    end
                    default: begin
                        if (in_byte_enable_reg[0]) begin
                            st_next.xmt_data = in_write_data_reg[7:0];
                        end
                        st_next = start_tx(st_next, load_time);
                    end
                endcase
            end
            KIND_CHAR: begin
                if (st_reg.xmt_status[XC_MAINT]) begin
                    acc = 1'b1;
                end else begin
                    acc     = ~st_reg.rcv_busy;
                    st_next = start_rx(st_reg, in_char_reg, load_time);
                end
            end
            KIND_TICK: begin
                // Transmitter first, so a looped-back start is not counted down
                if (st_reg.xmt_busy) begin
                    st_next.xmt_timer = st_reg.xmt_timer - TIMER_ONE;
                    if (st_next.xmt_timer == '0) begin
                        st_next.xmt_busy = 1'b0;
                        if (!st_reg.xmt_status[XC_MAINT]) begin
                            lv = 1'b1;
                            lc = st_reg.xmt_shift_char;
                        end
                        st_next.xmt_status[XC_RDY] = 1'b1;
                        if (st_reg.xmt_pending) begin
                            st_next = start_tx(st_next, load_time);
                        end else begin
                            st_next.irq_request = irq_level(st_next);
                        end
                    end
                end
                if (rx_was_busy && st_next.rcv_busy) begin
                    st_next.rcv_timer = st_next.rcv_timer - TIMER_ONE;
                    if (st_next.rcv_timer == '0) begin
                        st_next.rcv_busy   = 1'b0;
                        st_next.rcv_buffer = {8'd0, st_next.rcv_shift_char};
                        if (st_next.rcv_status[RC_DONE]) begin
                            st_next.rcv_buffer[RB_OVR] = 1'b1;
                            st_next.rcv_buffer[RB_ERR] = 1'b1;
                        end
                        st_next.rcv_status[RC_ACT]  = 1'b0;
                        st_next.rcv_status[RC_DONE] = 1'b1;
                        st_next.irq_request = irq_level(st_next);
                    end
                end
            end
            KIND_ACK: begin
                st_next.irq_request = 1'b0;
                if (st_reg.rcv_status[RC_DS_INT] || st_reg.rcv_status[RC_DONE]) begin
                    vec = {1'b0, vector_base_reg};
                end else if (st_reg.xmt_status[XC_RDY]) begin
                    vec = {1'b0, vector_base_reg} + XMT_VECTOR_OFS;
                end
            end
            KIND_RESET: st_next = reset_state();
            default: ;
        endcase

        out_data_next = {3'd0, vec, st_next.irq_request, lc, lv, acc, rd};
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_base_reg <= VECTOR_RESET;
            char_time_reg   <= CHAR_TIME_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                CFG_VECTOR:    vector_base_reg <= pwdata[8:0];
                CFG_CHAR_TIME: char_time_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register: take a transfer when empty or when the held item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg        <= s_tuser;
            in_reg_index_reg   <= s_tdata[1:0];
            in_write_data_reg  <= s_tdata[17:2];
            in_byte_enable_reg <= s_tdata[19:18];
            in_char_reg        <= s_tdata[27:20];
        end
    end

    // Device state: advance once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= reset_state();
        end else if (proc_fire) begin
            st_reg <= st_next;
        end
    end

    // Result register: load on process, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // Transmitter busy exactly when transmit ready is clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.xmt_busy != st_reg.xmt_status[XC_RDY])
        else $error("transmit busy and ready flags disagree");

    // A queued write only exists behind a character in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.xmt_pending |-> st_reg.xmt_busy)
        else $error("transmit write queued with transmitter idle");

    // Receiver active bit tracks the receive timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.rcv_busy == st_reg.rcv_status[RC_ACT])
        else $error("receiver active bit out of step with receiver");

    // A processed item always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

[test/tb_serial_line_unit_registers.sv]
// Self-checking testbench for the serial line unit register block.
// Drives item transfers and APB configuration writes, predicts every result.
// Depends on slu_pkg and serial_line_unit_registers.
`timescale 1ns / 1ps

module tb_serial_line_unit_registers;
    import slu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 6;

    // Kinds the block must ignore
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam logic [2:0] ADDR_VECTOR    = {CFG_VECTOR, 2'b00};
    localparam logic [2:0] ADDR_CHAR_TIME = {CFG_CHAR_TIME, 2'b00};

    // Result fields, lowest bit last, matching m_tdata[36:0]
    typedef struct packed {
        logic [9:0]  vec;
        logic        irq;
        logic [7:0]  line_char;
        logic        line_valid;
        logic        accepted;
        logic [15:0] rdata;
    } line_result_t;

    // Predicts the device registers and checks each result in order
    class line_unit_scoreboard;
        logic [15:0] rcsr, rbuf, xcsr;
        logic [7:0]  xbuf_char, tx_char, rx_char;
        logic [15:0] tx_count, rx_count;
        bit          tx_queued, tx_active, rx_active, irq_level;
        logic [8:0]  vector_reg;
        logic [15:0] ticks_reg;
        line_result_t expected_results[$];
        int n_checked, n_errors, n_line_chars, n_rx_done, n_overruns;

        function new();
            vector_reg = VECTOR_RESET;
            ticks_reg  = CHAR_TIME_RESET;
            n_checked = 0; n_errors = 0; n_line_chars = 0; n_rx_done = 0; n_overruns = 0;
            clear_device();
        endfunction

        function void set_config(logic [8:0] vec, logic [15:0] ticks);
            vector_reg = vec;
            ticks_reg  = ticks;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [15:0] char_time();
            return (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
        endfunction

        function logic [15:0] byte_merge(logic [15:0] old_w, logic [15:0] new_w,
                                         logic [1:0] be);
            logic [15:0] keep;
            keep = {{8{~be[1]}}, {8{~be[0]}}};
            return (old_w & keep) | (new_w & ~keep);
        endfunction

        function void refresh_irq();
            irq_level = (rcsr[RC_DS_ENB] && rcsr[RC_DS_INT]) ||
                        (rcsr[RC_INT_ENB] && rcsr[RC_DONE]) ||
                        (xcsr[XC_INT_ENB] && xcsr[XC_RDY]);
        endfunction

        function bit start_rx(logic [7:0] ch);
            if (rx_active) return 1'b0;
            rcsr[RC_ACT] = 1'b1;
            rx_active = 1'b1;
            rx_count  = char_time();
            rx_char   = ch;
            return 1'b1;
        endfunction

        // Queue behind a busy transmitter, else load the shifter
        function void start_tx();
            bit unused;
            if (!xcsr[XC_RDY]) begin
                tx_queued = 1'b1;
                return;
            end
            tx_queued = 1'b0;
            xcsr[XC_RDY] = 1'b0;
            tx_char   = xbuf_char;
            tx_active = 1'b1;
            tx_count  = char_time();
            if (xcsr[XC_MAINT]) unused = start_rx(tx_char);
            refresh_irq();
        endfunction

        function void clear_device();
            rcsr = '0; rbuf = '0; xcsr = XC_RESET; xbuf_char = '0;
            tx_queued = 0; tx_active = 0; rx_active = 0;
            tx_count = '0; rx_count = '0; tx_char = '0; rx_char = '0;
            irq_level = 0;
            refresh_irq();
        endfunction

        // Work out the result of one accepted input transfer
        function void note_transfer(logic [2:0] kind, logic [1:0] idx, logic [15:0] wd,
                                    logic [1:0] be, logic [7:0] ch);
            line_result_t r;
            logic [15:0] v;
            bit rx_was_active;
            r = '0;
            case (kind)
                KIND_READ: begin
                    case (idx)
                        REG_RCSR: begin
                            r.rdata = rcsr;
                            rcsr[RC_DS_INT] = 1'b0;
                            refresh_irq();
                        end
                        REG_RBUF: begin
                            r.rdata = rbuf;
                            rcsr[RC_DONE] = 1'b0;
                            refresh_irq();
                        end
                        REG_XCSR: r.rdata = xcsr;
                        default:  r.rdata = {8'h00, xbuf_char};
                    endcase
                end
                KIND_WRITE: begin
                    case (idx)
                        REG_RCSR: begin
                            v = byte_merge(rcsr, wd, be);
                            rcsr = (rcsr & ~RC_WMASK) | (v & RC_WMASK);
                            if (v[RC_RDR_ENB]) rcsr[RC_DONE] = 1'b0;
                            refresh_irq();
                        end
                        REG_RBUF: begin
                            rcsr[RC_DONE] = 1'b0;
                            refresh_irq();
                        end
                        REG_XCSR: begin
                            v = byte_merge(xcsr, wd, be);
                            xcsr = (xcsr & ~XC_WMASK) | (v & XC_WMASK);
                            // Maintenance drops any receive in progress
                            if (v[XC_MAINT]) begin
                                rx_active = 1'b0;
                                rx_count  = '0;
                                rcsr[RC_ACT] = 1'b0;
                            end
                            refresh_irq();
                        end
                        default: begin
                            v = byte_merge({8'h00, xbuf_char}, wd, be);
                            xbuf_char = v[7:0];
                            start_tx();
                        end
                    endcase
                end
                KIND_CHAR: begin
                    r.accepted = xcsr[XC_MAINT] ? 1'b1 : start_rx(ch);
                end
                KIND_TICK: begin
                    rx_was_active = rx_active;
                    // Transmit side completes first
                    if (tx_active) begin
                        tx_count = tx_count - 16'd1;
                        if (tx_count == 16'd0) begin
                            tx_active = 1'b0;
                            if (!xcsr[XC_MAINT]) begin
                                r.line_valid = 1'b1;
                                r.line_char  = tx_char;
                                n_line_chars++;
                            end
                            xcsr[XC_RDY] = 1'b1;
                            if (tx_queued) start_tx();
                            else refresh_irq();
                        end
                    end
                    if (rx_was_active && rx_active) begin
                        rx_count = rx_count - 16'd1;
                        if (rx_count == 16'd0) begin
                            rx_active = 1'b0;
                            rbuf = {8'h00, rx_char};
                            if (rcsr[RC_DONE]) begin
                                rbuf[RB_OVR] = 1'b1;
                                rbuf[RB_ERR] = 1'b1;
                                n_overruns++;
                            end
                            rcsr[RC_ACT]  = 1'b0;
                            rcsr[RC_DONE] = 1'b1;
                            n_rx_done++;
                            refresh_irq();
                        end
                    end
                end
                KIND_ACK: begin
                    irq_level = 1'b0;
                    if (rcsr[RC_DS_INT] || rcsr[RC_DONE]) r.vec = {1'b0, vector_reg};
                    else if (xcsr[XC_RDY]) r.vec = {1'b0, vector_reg} + XMT_VECTOR_OFS;
                end
                KIND_RESET: clear_device();
                default: ;
            endcase
            r.irq = irq_level;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %h, got %h", name, exp_v, got_v);
                n_errors++;
            end
        endfunction

        function void check_result(line_result_t got);
            line_result_t exp_r;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %h", got);
                n_errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            n_checked++;
            compare_field("read_data", exp_r.rdata, got.rdata);
            compare_field("char_accepted", 16'(exp_r.accepted), 16'(got.accepted));
            compare_field("line_out_valid", 16'(exp_r.line_valid), 16'(got.line_valid));
            compare_field("line_out_char", 16'(exp_r.line_char), 16'(got.line_char));
            compare_field("irq_line", 16'(exp_r.irq), 16'(got.irq));
            compare_field("ack_vector", 16'(exp_r.vec), 16'(got.vec));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // reg_index[1:0], write_data[17:2],
                                  // byte_enable[19:18], incoming_char[27:20]
    logic [2:0]  s_tuser  = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // read_data[15:0], char_accepted[16],
                                  // line_out_valid[17], line_out_char[25:18],
                                  // irq_line[26], ack_vector[36:27]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    line_unit_scoreboard sb = new();
    bit steady = 1'b0;
    int cycle_count = 0;
    int n_settings = 0;

    serial_line_unit_registers u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Stop a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each transfer, stall at random, hold off once for long
    initial begin : result_side
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(line_result_t'(m_tdata[36:0]));
                stall = steady ? 0 : $urandom_range(0, 3);
                if (sb.n_checked == HOLD_AT) hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [1:0] idx,
                             input logic [15:0] wd, input logic [1:0] be,
                             input logic [7:0] ch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'h0, ch, be, wd, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_transfer(kind, idx, wd, be, ch);
    endtask

    task automatic send_random();
        int pick;
        logic [2:0] kind;
        logic [1:0] be;
        pick = $urandom_range(0, 99);
        kind = (pick < 38) ? KIND_TICK :
               (pick < 56) ? KIND_READ :
               (pick < 78) ? KIND_WRITE :
               (pick < 90) ? KIND_CHAR :
               (pick < 98) ? KIND_ACK : KIND_RESET;
        be = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        send_item(kind, 2'($urandom_range(0, 3)), 16'($urandom), be, 8'($urandom));
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain all results, then rewrite both registers
    task automatic set_config(input logic [8:0] vec, input logic [15:0] ticks);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        apb_write(ADDR_VECTOR, {23'h0, vec});
        apb_write(ADDR_CHAR_TIME, {16'h0, ticks});
        sb.set_config(vec, ticks);
        n_settings++;
    endtask

    task automatic run_phase(input logic [8:0] vec, input logic [15:0] ticks, input int n);
        set_config(vec, ticks);
        steady = ($urandom_range(0, 3) == 0);
        repeat (n) send_random();
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: plain register reads, ack with only transmit ready,
        // ignored kinds, busy receiver refusing a character
        send_item(KIND_READ, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_RBUF, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_XCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_XBUF, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_ACK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_SPARE_A, REG_XBUF, 16'hFFFF, 2'd3, 8'hFF);
        send_item(KIND_SPARE_B, REG_RCSR, 16'hFFFF, 2'd3, 8'hFF);
        send_item(KIND_CHAR, REG_RCSR, 16'h0000, 2'd3, 8'hFF);
        send_item(KIND_CHAR, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_TICK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        s_tvalid <= 1'b0;

        // Top vector and a zero character time (counts as one tick)
        set_config(9'd508, 16'd0);
        send_item(KIND_WRITE, REG_RCSR, 16'hFFFF, 2'd3, 8'h00);
        send_item(KIND_WRITE, REG_XCSR, 16'h0045, 2'd1, 8'h00);
        send_item(KIND_ACK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        // Loopback: buffer write without byte enables, then one queued behind it
        send_item(KIND_WRITE, REG_XBUF, 16'h00A5, 2'd0, 8'h00);
        send_item(KIND_WRITE, REG_XBUF, 16'hFF5A, 2'd3, 8'h00);
        send_item(KIND_CHAR, REG_RCSR, 16'h0000, 2'd3, 8'h33);
        send_item(KIND_TICK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_TICK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_WRITE, REG_XCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_WRITE, REG_XBUF, 16'h00C3, 2'd1, 8'h00);
        send_item(KIND_CHAR, REG_RCSR, 16'h0000, 2'd3, 8'h81);
        send_item(KIND_TICK, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_RBUF, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_WRITE, REG_RBUF, 16'h0000, 2'd2, 8'h00);
        send_item(KIND_WRITE, REG_RCSR, 16'hFF00, 2'd2, 8'h00);
        send_item(KIND_RESET, REG_RCSR, 16'h0000, 2'd3, 8'h00);
        send_item(KIND_READ, REG_XCSR, 16'h0000, 2'd3, 8'h00);
        s_tvalid <= 1'b0;

        // Random phases: extremes first, then short character times
        run_phase(9'd0, 16'd65535, 80);
        run_phase(9'd508, 16'd1, 280);
        run_phase(9'($urandom_range(0, 508)), 16'($urandom_range(1, 8)), 280);
        run_phase(9'($urandom_range(0, 508)), 16'($urandom_range(2, 6)), 280);
        run_phase(9'($urandom_range(0, 508)), 16'd1, 280);
        run_phase(9'($urandom_range(0, 508)), 16'($urandom_range(1, 8)), 280);

        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Checked %0d results over %0d register settings", sb.n_checked, n_settings);
        $display("Line characters sent %0d, received %0d, overruns %0d",
                 sb.n_line_chars, sb.n_rx_done, sb.n_overruns);
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
